// ===== rtl/core/ps2me_pkg.sv =====
`default_nettype none

package ps2me_pkg;

    // input selector carried in tuser
    localparam logic OP_HOST   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // host commands
    localparam logic [7:0] CMD_RESET    = 8'hFF;
    localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
    localparam logic [7:0] CMD_DISABLE  = 8'hF5;
    localparam logic [7:0] CMD_STREAM   = 8'hEA;
    localparam logic [7:0] CMD_ENABLE   = 8'hF4;
    localparam logic [7:0] CMD_SET_RATE = 8'hF3;
    localparam logic [7:0] CMD_GET_ID   = 8'hF2;
    localparam logic [7:0] CMD_STATUS   = 8'hE9;

    // device replies
    localparam logic [7:0] RSP_ACK      = 8'hFA;
    localparam logic [7:0] RSP_SELFTEST = 8'hAA;
    localparam logic [7:0] RSP_STATUS1  = 8'h00;
    localparam logic [7:0] RSP_STATUS2  = 8'h02;

    localparam logic [7:0] RATE_DEFAULT = 8'd100;

    // sample rate knocks: 200,100,80 and 200,200,80
    localparam logic [31:0] KNOCK_WHEEL = 32'h00C8_6450;
    localparam logic [31:0] KNOCK_5BTN  = 32'h00C8_C850;

    localparam logic [2:0] ID_STD   = 3'd0;
    localparam logic [2:0] ID_WHEEL = 3'd3;
    localparam logic [2:0] ID_5BTN  = 3'd4;

    localparam int IN_DATA_W = 40;

    // one reply: up to four bytes, sent from index 0 up to last_idx
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ps2me_front.sv =====
`default_nettype none

module ps2me_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ps2me_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                            s_tuser,
    input  wire ps2me_pkg::q_status_t            q_status,
    output logic                                 push,
    output ps2me_pkg::packet_t                   push_pkt
);

    logic [2:0]  device_id_reg, device_id_next;
    logic        streaming_reg, streaming_next;
    logic        awaiting_reg, awaiting_next;
    logic [7:0]  rate_reg, rate_next;
    logic [31:0] hist_reg, hist_next;

    logic [7:0]  host_byte, button_bits, dx_raw, dy_raw, wheel_raw;
    logic [31:0] hist_shift;
    logic        accept;
    logic        has_reply;
    logic [7:0]  s_byte, y_byte;
    logic [7:0]  z_byte;
    logic [2:0]  z_mag;
    logic [6:0]  y_mag;
    logic        wheel_mode;

    assign host_byte   = s_tdata[7:0];
    assign button_bits = s_tdata[15:8];
    assign dx_raw      = s_tdata[23:16];
    assign dy_raw      = s_tdata[31:24];
    assign wheel_raw   = s_tdata[39:32];

    assign s_tready   = !q_status.full;
    assign accept     = s_tvalid && s_tready;
    assign hist_shift = {hist_reg[23:0], host_byte};
    assign wheel_mode = (device_id_reg == ps2me_pkg::ID_WHEEL)
                     || (device_id_reg == ps2me_pkg::ID_5BTN);
    assign y_mag      = dy_raw[6:0];
    assign z_mag      = wheel_raw[2:0];

    // report coding: y is sent negated, sign bits land in the status byte
    always_comb
    begin
        s_byte = {4'b0000, 1'b1, button_bits[2:0]};
        s_byte[4] = dx_raw[7];
        if (dy_raw[7])
        begin
            y_byte = 8'h80 - {1'b0, y_mag};
        end
        else if (y_mag != 7'd0)
        begin
            s_byte[5] = 1'b1;
            y_byte = 8'h00 - {1'b0, y_mag};
        end
        else
        begin
            y_byte = 8'h00;
        end
        if (wheel_raw[7])
        begin
            z_byte = 8'd8 - {5'd0, z_mag};
        end
        else if (z_mag != 3'd0)
        begin
            z_byte = 8'd16 - {5'd0, z_mag};
        end
        else
        begin
            z_byte = 8'd0;
        end
        if (device_id_reg == ps2me_pkg::ID_5BTN)
        begin
            z_byte[4] = button_bits[3];
            z_byte[5] = button_bits[4];
        end
    end

    always_comb
    begin
        device_id_next = device_id_reg;
        streaming_next = streaming_reg;
        awaiting_next  = awaiting_reg;
        rate_next      = rate_reg;
        hist_next      = hist_reg;
        has_reply      = 1'b1;
        push_pkt.bytes    = {4{ps2me_pkg::RSP_ACK}};
        push_pkt.last_idx = 2'd0;

        if (s_tuser == ps2me_pkg::OP_REPORT)
        begin
            has_reply = streaming_reg;
            push_pkt.bytes[0] = s_byte;
            push_pkt.bytes[1] = dx_raw;
            push_pkt.bytes[2] = y_byte;
            push_pkt.bytes[3] = z_byte;
            push_pkt.last_idx = wheel_mode ? 2'd3 : 2'd2;
        end
        else if (awaiting_reg)
        begin
            rate_next     = host_byte;
            awaiting_next = 1'b0;
            hist_next     = hist_shift;
            if (device_id_reg == ps2me_pkg::ID_STD && hist_shift == ps2me_pkg::KNOCK_WHEEL)
            begin
                device_id_next = ps2me_pkg::ID_WHEEL;
            end
            else if (device_id_reg == ps2me_pkg::ID_WHEEL
                     && hist_shift == ps2me_pkg::KNOCK_5BTN)
            begin
                device_id_next = ps2me_pkg::ID_5BTN;
            end
        end
        else
        begin
            if (host_byte != ps2me_pkg::CMD_SET_RATE)
            begin
                hist_next = 32'd0;
            end
            case (host_byte)
                ps2me_pkg::CMD_RESET:
                begin
                    device_id_next = ps2me_pkg::ID_STD;
                    streaming_next = 1'b0;
                    rate_next      = ps2me_pkg::RATE_DEFAULT;
                    push_pkt.bytes[1] = ps2me_pkg::RSP_SELFTEST;
                    push_pkt.bytes[2] = {5'd0, ps2me_pkg::ID_STD};
                    push_pkt.last_idx = 2'd2;
                end
                ps2me_pkg::CMD_DEFAULTS:
                begin
                    device_id_next = ps2me_pkg::ID_STD;
                    streaming_next = 1'b0;
                    rate_next      = ps2me_pkg::RATE_DEFAULT;
                end
                ps2me_pkg::CMD_DISABLE, ps2me_pkg::CMD_STREAM:
                begin
                    streaming_next = 1'b0;
                end
                ps2me_pkg::CMD_ENABLE:
                begin
                    streaming_next = 1'b1;
                end
                ps2me_pkg::CMD_SET_RATE:
                begin
                    awaiting_next = 1'b1;
                end
                ps2me_pkg::CMD_GET_ID:
                begin
                    push_pkt.bytes[1] = {5'd0, device_id_reg};
                    push_pkt.last_idx = 2'd1;
                end
                ps2me_pkg::CMD_STATUS:
                begin
                    push_pkt.bytes[1] = ps2me_pkg::RSP_STATUS1;
                    push_pkt.bytes[2] = ps2me_pkg::RSP_STATUS2;
                    push_pkt.bytes[3] = rate_reg;
                    push_pkt.last_idx = 2'd3;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push = accept && has_reply;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= ps2me_pkg::ID_STD;
            streaming_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            rate_reg      <= ps2me_pkg::RATE_DEFAULT;
            hist_reg      <= 32'd0;
        end
        else if (accept)
        begin
            device_id_reg <= device_id_next;
            streaming_reg <= streaming_next;
            awaiting_reg  <= awaiting_next;
            rate_reg      <= rate_next;
            hist_reg      <= hist_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ps2me_queue.sv =====
`default_nettype none

module ps2me_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ps2me_pkg::packet_t   push_pkt,
    input  wire logic                 pop,
    output ps2me_pkg::packet_t        head,
    output ps2me_pkg::q_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ps2me_pkg::packet_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ps2me_back.sv =====
`default_nettype none

module ps2me_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ps2me_pkg::packet_t   head,
    input  wire ps2me_pkg::q_status_t q_status,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    // output register refills, while the queue holds a reply, whenever it is empty or being taken
    assign load    = !q_status.empty && (!valid_reg || m_tready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= head.bytes[idx_reg];
            last_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ps2_mouse_emulator.sv =====
// ps2 mouse device model with wheel and five-button extensions. each request on the
// slave side is a host command byte (tuser 0) or a usb boot mouse report (tuser 1);
// its reply bytes (ack plus replies, or a 3 or 4 byte movement packet while streaming)
// leave on the master side one byte per cycle while m_tready is high, with tlast on
// the final byte of each reply. a request that yields no bytes (report while not
// streaming) produces nothing. replies wait in a queue of QUEUE_DEPTH packets; the
// slave side stalls only when that queue is full. the first byte of a reply passes
// through that queue and then the output register before it is valid.

`default_nettype none

module ps2_mouse_emulator
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // host_byte[7:0], button_bits[15:8], dx_raw[23:16], dy_raw[31:24], wheel_raw[39:32]
    input  wire logic [ps2me_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_byte[7:0]
    output logic [7:0]                           m_tdata,
    output logic                                 m_tlast
);

    logic                 push;
    logic                 pop;
    ps2me_pkg::packet_t   push_pkt;
    ps2me_pkg::packet_t   head;
    ps2me_pkg::q_status_t q_status;

    ps2me_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_pkt (push_pkt)
    );

    ps2me_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    ps2me_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // every accepted host command must queue a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ps2me_pkg::OP_HOST) |-> push)
        else $error("host command accepted without reply");

    // back end never drains an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty reply queue");

    // queue cannot be both full and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("reply queue status inconsistent");
`endif

endmodule

`default_nettype wire

// ===== tb/ps2_mouse_emulator_tb.sv =====
`timescale 1ns / 1ps

module ps2_mouse_emulator_tb;

    import ps2me_pkg::*;

    localparam int RANDOM_REPLIES = 65;
    localparam int IDLE_PCT       = 37;
    localparam int OUT_HOLD_LEN   = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic       opcode;
        logic [7:0] host_byte;
        logic [7:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] wheel;
    } mouse_req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } host_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    mouse_req_t  req_pending [$];
    mouse_req_t  req_on_bus;
    host_byte_t  host_bytes_due [$];

    // mouse state as seen by the host
    logic [2:0]  mouse_id = ID_STD;
    logic        streaming = 1'b0;
    logic        rate_next = 1'b0;
    logic [7:0]  rate = RATE_DEFAULT;
    logic [31:0] rate_log = '0;

    int          replied_reqs = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          out_hold_left = 0;
    logic        want_hold = 1'b0;
    logic        hold_taken = 1'b0;
    logic        calm = 1'b0;

    always #1 clk = ~clk;

    ps2_mouse_emulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    task automatic note_error(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // work out the bytes a request sends back and update the mouse state
    task automatic predict_reply(input mouse_req_t r, output int n_bytes);
        logic [7:0] reply [$];
        logic [7:0] stat;
        logic [7:0] ymv;
        logic [7:0] zmv;
        logic [2:0] z3;
        if (r.opcode == OP_HOST)
        begin
            reply.push_back(RSP_ACK);
            if (rate_next)
            begin
                rate      = r.host_byte;
                rate_next = 1'b0;
                rate_log  = {rate_log[23:0], r.host_byte};
                if (mouse_id == ID_STD && rate_log == KNOCK_WHEEL)
                    mouse_id = ID_WHEEL;
                else if (mouse_id == ID_WHEEL && rate_log == KNOCK_5BTN)
                    mouse_id = ID_5BTN;
            end
            else
            begin
                if (r.host_byte != CMD_SET_RATE)
                    rate_log = '0;
                case (r.host_byte)
                    CMD_RESET:
                    begin
                        mouse_id  = ID_STD;
                        streaming = 1'b0;
                        rate      = RATE_DEFAULT;
                        reply.push_back(RSP_SELFTEST);
                        reply.push_back({5'b0, mouse_id});
                    end
                    CMD_DEFAULTS:
                    begin
                        mouse_id  = ID_STD;
                        streaming = 1'b0;
                        rate      = RATE_DEFAULT;
                    end
                    CMD_DISABLE, CMD_STREAM: streaming = 1'b0;
                    CMD_ENABLE:              streaming = 1'b1;
                    CMD_SET_RATE:            rate_next = 1'b1;
                    CMD_GET_ID:              reply.push_back({5'b0, mouse_id});
                    CMD_STATUS:
                    begin
                        reply.push_back(RSP_STATUS1);
                        reply.push_back(RSP_STATUS2);
                        reply.push_back(rate);
                    end
                    default: ;
                endcase
            end
        end
        else if (streaming)
        begin
            // y is flipped: usb counts down as positive, ps2 counts up
            ymv  = r.dy[7] ? 8'h80 - {1'b0, r.dy[6:0]} : -r.dy;
            stat = {2'b00, (!r.dy[7] && r.dy != 8'h00), r.dx[7], 1'b1, r.buttons[2:0]};
            reply.push_back(stat);
            reply.push_back(r.dx);
            reply.push_back(ymv);
            if (mouse_id == ID_WHEEL || mouse_id == ID_5BTN)
            begin
                z3 = r.wheel[2:0];
                if (r.wheel[7])
                    zmv = 8'd8 - {5'b0, z3};
                else if (z3 != 3'd0)
                    zmv = 8'd16 - {5'b0, z3};
                else
                    zmv = 8'h00;
                if (mouse_id == ID_5BTN)
                    zmv = zmv + {2'b00, r.buttons[4], r.buttons[3], 4'b0000};
                reply.push_back(zmv);
            end
        end
        n_bytes = reply.size();
        for (int i = 0; i < reply.size(); i++)
            host_bytes_due.push_back('{data: reply[i], last: (i == reply.size() - 1)});
    endtask

    // sender: one request on the bus at a time, held until taken
    always @(posedge clk or negedge rst_n)
    begin
        int n_bytes;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_reply(req_on_bus, n_bytes);
                if (n_bytes > 0)
                    replied_reqs <= replied_reqs + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_on_bus = req_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req_on_bus.opcode;
                    s_tdata  <= {req_on_bus.wheel, req_on_bus.dy, req_on_bus.dx,
                                 req_on_bus.buttons, req_on_bus.host_byte};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each byte against the oldest one due
    always @(posedge clk or negedge rst_n)
    begin
        host_byte_t due;
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            out_hold_left <= 0;
            hold_taken    <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (host_bytes_due.size() == 0)
                begin
                    note_error($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
                end
                else
                begin
                    due = host_bytes_due.pop_front();
                    if (m_tdata !== due.data || m_tlast !== due.last)
                        note_error($sformatf("byte mismatch: expected %h last %b, got %h last %b",
                                             due.data, due.last, m_tdata, m_tlast));
                end
            end
            if (want_hold && !hold_taken)
            begin
                hold_taken    <= 1'b1;
                out_hold_left <= OUT_HOLD_LEN;
                m_tready      <= 1'b0;
            end
            else if (out_hold_left > 0)
            begin
                out_hold_left <= out_hold_left - 1;
                m_tready      <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("ps2_mouse_emulator_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [7:0] b);
        req_pending.push_back('{opcode: OP_HOST, host_byte: b,
                                buttons: 8'($urandom_range(255)), dx: 8'($urandom_range(255)),
                                dy: 8'($urandom_range(255)), wheel: 8'($urandom_range(255))});
    endtask

    task automatic push_report(input logic [7:0] btn, input logic [7:0] dx,
                               input logic [7:0] dy, input logic [7:0] wh);
        req_pending.push_back('{opcode: OP_REPORT, host_byte: 8'($urandom_range(255)),
                                buttons: btn, dx: dx, dy: dy, wheel: wh});
    endtask

    task automatic push_random_report();
        push_report(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic push_rate(input logic [7:0] r);
        push_cmd(CMD_SET_RATE);
        push_cmd(r);
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || s_tvalid || host_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // one short well-formed sequence, now and then a broken one or plain noise
    task automatic queue_random_burst();
        logic [7:0] cmds [7];
        logic [31:0] knock;
        int pick;
        cmds = '{CMD_RESET, CMD_DEFAULTS, CMD_DISABLE, CMD_STREAM,
                 CMD_ENABLE, CMD_GET_ID, CMD_STATUS};
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if ($urandom_range(2) == 0)
                push_cmd(CMD_ENABLE);
            repeat ($urandom_range(1, 4)) push_random_report();
        end
        else if (pick < 60)
        begin
            if ($urandom_range(3) == 0)
                push_cmd(CMD_RESET);
            push_cmd(CMD_ENABLE);
            knock = $urandom_range(1) ? KNOCK_WHEEL : KNOCK_5BTN;
            if ($urandom_range(3) == 0)
                knock[8 * $urandom_range(2) +: 8] = 8'($urandom_range(255));
            push_rate(knock[23:16]);
            push_rate(knock[15:8]);
            push_rate(knock[7:0]);
            repeat ($urandom_range(1, 2)) push_random_report();
        end
        else if (pick < 70)
        begin
            push_rate(8'($urandom_range(255)));
        end
        else if (pick < 88)
        begin
            push_cmd(cmds[$urandom_range(6)]);
        end
        else
        begin
            push_cmd(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_cmd(CMD_STATUS);
        push_cmd(CMD_GET_ID);
        push_random_report();                       // not streaming yet, no reply
        push_cmd(CMD_ENABLE);
        push_report(8'hFF, 8'h80, 8'h80, 8'h80);
        push_report(8'h00, 8'h7F, 8'h7F, 8'h7F);
        push_rate(KNOCK_WHEEL[23:16]);
        push_rate(KNOCK_WHEEL[15:8]);
        push_rate(KNOCK_WHEEL[7:0]);
        push_cmd(CMD_GET_ID);
        push_report(8'h18, 8'h01, 8'h00, 8'h81);
        push_rate(KNOCK_5BTN[23:16]);
        push_rate(KNOCK_5BTN[15:8]);
        push_rate(KNOCK_5BTN[7:0]);
        push_report(8'h1F, 8'hFF, 8'hFF, 8'hF8);
        push_cmd(CMD_STATUS);
        push_cmd(CMD_DISABLE);
        push_cmd(CMD_STREAM);
        push_cmd(CMD_DEFAULTS);
        push_cmd(CMD_RESET);
        push_cmd(8'h00);                            // unknown command, ack only
        wait_drained();

        base = replied_reqs;
        // back up the output while the sender keeps offering requests
        push_cmd(CMD_ENABLE);
        repeat (12) push_random_report();
        want_hold = 1'b1;

        while (replied_reqs - base < RANDOM_REPLIES)
        begin
            calm = (replied_reqs - base >= 25) && (replied_reqs - base < 50);
            if (req_pending.size() < 6)
                queue_random_burst();
            else
                @(negedge clk);
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (host_bytes_due.size() != 0)
            note_error($sformatf("%0d reply bytes never arrived", host_bytes_due.size()));

        if (mismatches == 0)
            $display("ps2_mouse_emulator_tb: PASS");
        else
            $display("ps2_mouse_emulator_tb: FAIL");
        $finish;
    end

endmodule

// ===== ps2_mouse_emulator.f =====
rtl/core/ps2me_pkg.sv
rtl/core/ps2me_front.sv
rtl/core/ps2me_queue.sv
rtl/core/ps2me_back.sv
rtl/core/ps2_mouse_emulator.sv
tb/ps2_mouse_emulator_tb.sv
